>>> hdl/ltk_pkg.sv
package ltk_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EMIT
    } t_state;

    typedef logic [1:0] t_status;

    localparam t_status STAT_DATA = 2'd0;
    localparam t_status STAT_NONE = 2'd1;
    localparam t_status STAT_OVF  = 2'd2;

    localparam logic [7:0] XOR_FIRST = 8'd5;
    localparam logic [7:0] ESC_V0    = 8'd0;
    localparam logic [7:0] ESC_V1    = 8'd5;
    localparam logic [7:0] ESC_V2    = 8'd36;
    localparam logic [7:0] ESC_V3    = 8'd96;
    localparam logic [7:0] ESC_V4    = 8'd124;
    localparam logic [7:0] ESC_V5    = 8'd126;

    localparam logic [3:0] ESC_LAST  = 4'd9;
    localparam logic [3:0] MIN_KEY   = 4'd3;

    function automatic logic [7:0] nib_swap(input logic [7:0] v);
        return {v[3:0], v[7:4]};
    endfunction

    function automatic logic needs_escape(input logic [7:0] v);
        return (v == ESC_V0) || (v == ESC_V1) || (v == ESC_V2) ||
               (v == ESC_V3) || (v == ESC_V4) || (v == ESC_V5);
    endfunction

    // three decimal digits, hundreds in the top byte
    function automatic logic [23:0] esc_digits(input logic [7:0] v);
        logic [23:0] d;
        case (v)
            ESC_V1:  d = "005";
            ESC_V2:  d = "036";
            ESC_V3:  d = "096";
            ESC_V4:  d = "124";
            ESC_V5:  d = "126";
            default: d = "000";
        endcase
        return d;
    endfunction

    function automatic logic [7:0] esc_char(input logic [7:0] v, input logic [3:0] k);
        logic [23:0] d;
        logic [7:0]  c;
        d = esc_digits(v);
        case (k)
            4'd0:    c = "/";
            4'd1:    c = "%";
            4'd2:    c = "D";
            4'd3:    c = "C";
            4'd4:    c = "N";
            4'd5:    c = d[23:16];
            4'd6:    c = d[15:8];
            4'd7:    c = d[7:0];
            4'd8:    c = "%";
            default: c = "/";
        endcase
        return c;
    endfunction

endpackage

>>> hdl/ltk_key_ram.sv
module ltk_key_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/lock_to_key_transform_top.sv
// Lock-to-key transform. Load items (tuser 0) feed lock bytes in tdata, tlast on the final
// byte; loads are taken back to back. Drain items (tuser 1) return the next key byte, as
// itself or as the ten-character escape /%DCN###%/, one character per cycle while the
// receiver is ready, with tlast on the last one; tuser carries the status in bits 1:0 and the
// key-finished flag in bit 2. A drain that returns a status only goes straight to the emit
// state; a drain that returns key data first passes a read state for the registered read of
// the key memory, then the character sequencer emits the byte or its escape. Key bytes sit in
// a MAX_LOCK-entry memory that needs no clearing after reset; the block takes one item at a time.
module lock_to_key_transform_top
    import ltk_pkg::*;
#(
    parameter int MAX_LOCK = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // lock_byte
    input  logic       i_s_tuser,   // op
    input  logic       i_s_tlast,   // lock_end
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // key_char
    output logic [2:0] o_m_tuser,   // status[1:0], key_finished
    output logic       o_m_tlast    // run_last
);

    localparam int CW = $clog2(MAX_LOCK + 1);
    localparam int IW = $clog2(MAX_LOCK);

    t_state        r_state, n_state;
    logic [7:0]    r_prev, n_prev;
    logic [7:0]    r_fkp, n_fkp;
    logic [7:0]    r_fkv, n_fkv;
    logic [7:0]    r_key0, n_key0;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_emit, n_emit;
    logic          r_done, n_done;
    logic          r_ovf, n_ovf;
    logic [7:0]    r_val, n_val;
    logic          r_esc, n_esc;
    t_status       r_stat, n_stat;
    logic          r_fin, n_fin;
    logic          r_first, n_first;
    logic [3:0]    r_chr, n_chr;

    logic          in_acc, out_acc, is_drain, has_data, char_last;
    logic          ram_we, ram_re;
    logic [IW-1:0] ram_waddr;
    logic [7:0]    ram_wdata, ram_rdata, key_v;
    logic [CW-1:0] base_cnt;

    assign in_acc    = i_s_tvalid && o_s_tready;
    assign out_acc   = o_m_tvalid && i_m_tready;
    assign is_drain  = i_s_tuser;
    assign has_data  = r_done && !r_ovf && (r_cnt >= CW'(MIN_KEY)) && (r_emit < r_cnt);
    assign char_last = !r_esc || (r_chr == ESC_LAST);
    assign base_cnt  = r_done ? '0 : r_cnt;
    assign key_v     = r_first ? r_key0 : ram_rdata;

    ltk_key_ram #(
        .DEPTH (MAX_LOCK),
        .AW    (IW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_emit[IW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc && is_drain) begin
                    n_state = has_data ? ST_READ : ST_EMIT;
                end
            end
            ST_READ: n_state = ST_EMIT;
            ST_EMIT: begin
                if (out_acc && char_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_s_tready = 1'b0;
        o_m_tvalid = 1'b0;
        case (r_state)
            ST_IDLE: o_s_tready = 1'b1;
            ST_EMIT: o_m_tvalid = 1'b1;
            default: begin
                o_s_tready = 1'b0;
                o_m_tvalid = 1'b0;
            end
        endcase
    end

    assign o_m_tdata = r_esc ? esc_char(r_val, r_chr) : r_val;
    assign o_m_tlast = char_last;
    assign o_m_tuser = {r_fin && char_last && (r_stat == STAT_DATA), r_stat};

    always_comb begin
        n_prev    = r_prev;
        n_fkp     = r_fkp;
        n_fkv     = r_fkv;
        n_key0    = r_key0;
        n_cnt     = r_cnt;
        n_emit    = r_emit;
        n_done    = r_done;
        n_ovf     = r_ovf;
        n_val     = r_val;
        n_esc     = r_esc;
        n_stat    = r_stat;
        n_fin     = r_fin;
        n_first   = r_first;
        n_chr     = r_chr;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_waddr = r_cnt[IW-1:0];
        ram_wdata = nib_swap(i_s_tdata ^ r_prev);

        if (in_acc && !is_drain) begin
            n_cnt  = base_cnt;
            n_emit = r_done ? '0 : r_emit;
            n_ovf  = r_done ? 1'b0 : r_ovf;
            n_done = 1'b0;
            if (base_cnt >= CW'(MAX_LOCK)) begin
                n_ovf = 1'b1;
            end else begin
                if (base_cnt == '0) begin
                    n_fkp = nib_swap(i_s_tdata ^ XOR_FIRST);
                    n_fkv = nib_swap(i_s_tdata ^ XOR_FIRST);
                end else begin
                    n_fkv     = ram_wdata;
                    ram_we    = 1'b1;
                    ram_waddr = base_cnt[IW-1:0];
                end
                n_prev = i_s_tdata;
                n_cnt  = base_cnt + 1'b1;
            end
            if (i_s_tlast) begin
                n_key0 = n_fkp ^ n_fkv;
                n_done = 1'b1;
            end
        end else if (in_acc && is_drain) begin
            n_val = '0;
            n_esc = 1'b0;
            n_fin = 1'b0;
            n_chr = '0;
            if (!r_done) begin
                n_stat = STAT_NONE;
            end else if (r_ovf) begin
                n_stat = STAT_OVF;
            end else if (!has_data) begin
                n_stat = STAT_NONE;
            end else begin
                n_stat  = STAT_DATA;
                n_fin   = (r_emit + 1'b1) == r_cnt;
                n_first = (r_emit == '0);
                n_emit  = r_emit + 1'b1;
                ram_re  = 1'b1;
            end
        end

        if (r_state == ST_READ) begin
            n_val = key_v;
            n_esc = needs_escape(key_v);
        end

        if (out_acc && !char_last) begin
            n_chr = r_chr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_prev  <= '0;
            r_fkp   <= '0;
            r_fkv   <= '0;
            r_key0  <= '0;
            r_cnt   <= '0;
            r_emit  <= '0;
            r_done  <= 1'b0;
            r_ovf   <= 1'b0;
            r_stat  <= STAT_NONE;
            r_fin   <= 1'b0;
            r_first <= 1'b0;
            r_chr   <= '0;
            r_esc   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_prev  <= n_prev;
            r_fkp   <= n_fkp;
            r_fkv   <= n_fkv;
            r_key0  <= n_key0;
            r_cnt   <= n_cnt;
            r_emit  <= n_emit;
            r_done  <= n_done;
            r_ovf   <= n_ovf;
            r_stat  <= n_stat;
            r_fin   <= n_fin;
            r_first <= n_first;
            r_chr   <= n_chr;
            r_esc   <= n_esc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

>>> hdl/ltk_checker.sv
module ltk_checker
    import ltk_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_s_tready,
    input logic       o_m_tvalid,
    input logic       i_m_tready,
    input logic [7:0] o_m_tdata,
    input logic [2:0] o_m_tuser,
    input logic       o_m_tlast
);

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid right after reset");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !o_s_tready)
        else $error("input taken while a result is pending");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("stalled item changed");

    a_finished_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[2] |-> o_m_tlast && (o_m_tuser[1:0] == STAT_DATA))
        else $error("key finished off the last data character");

    a_status_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser[1:0] != STAT_DATA) |-> o_m_tlast && (o_m_tdata == 8'd0))
        else $error("status item not a single zero character");

endmodule

bind lock_to_key_transform_top ltk_checker u_ltk_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);

>>> test/lock_to_key_transform_top_tb.sv
`timescale 1ns / 100ps

import ltk_pkg::*;

typedef struct packed {
    logic [7:0] ch;
    t_status    st;
    logic       last;
    logic       fin;
} t_key_char;

class key_char_ledger;
    localparam int LOCK_DEPTH = 256;
    localparam logic OP_LOAD  = 1'b0;

    logic [7:0]  key_mem [LOCK_DEPTH];
    logic [7:0]  prev_byte;
    logic [7:0]  first_part;
    logic [7:0]  last_key;
    int unsigned loaded;
    int unsigned emit_pos;
    bit          lock_done;
    bit          dropped;
    t_key_char   pending_chars [$];
    int unsigned errors;

    function new();
        prev_byte  = '0;
        first_part = '0;
        last_key   = '0;
        loaded     = 0;
        emit_pos   = 0;
        lock_done  = 0;
        dropped    = 0;
        errors     = 0;
    endfunction

    function void add_char(logic [7:0] ch, t_status st, logic last, logic fin);
        t_key_char e;
        e.ch   = ch;
        e.st   = st;
        e.last = last;
        e.fin  = fin;
        pending_chars.push_back(e);
    endfunction

    function void take_lock_item(logic op, logic [7:0] b, logic lock_end);
        logic [7:0] v;
        logic [7:0] mixed;
        logic [7:0] ch;
        logic       fin;
        if (op == OP_LOAD) begin
            if (lock_done) begin
                loaded    = 0;
                emit_pos  = 0;
                lock_done = 0;
                dropped   = 0;
            end
            if (loaded >= LOCK_DEPTH) begin
                dropped = 1;
            end else begin
                if (loaded == 0) begin
                    mixed      = b ^ XOR_FIRST;
                    first_part = {mixed[3:0], mixed[7:4]};
                    last_key   = first_part;
                end else begin
                    mixed               = b ^ prev_byte;
                    last_key            = {mixed[3:0], mixed[7:4]};
                    key_mem[8'(loaded)] = last_key;
                end
                prev_byte = b;
                loaded++;
            end
            if (lock_end) begin
                key_mem[0] = first_part ^ last_key;
                lock_done  = 1;
            end
            return;
        end
        if (!lock_done) begin
            add_char(8'd0, STAT_NONE, 1'b1, 1'b0);
        end else if (dropped) begin
            add_char(8'd0, STAT_OVF, 1'b1, 1'b0);
        end else if (loaded < 3 || emit_pos >= loaded || emit_pos >= LOCK_DEPTH) begin
            add_char(8'd0, STAT_NONE, 1'b1, 1'b0);
        end else begin
            v   = key_mem[8'(emit_pos)];
            fin = (emit_pos + 1 == loaded);
            emit_pos++;
            if (!(v inside {ESC_V0, ESC_V1, ESC_V2, ESC_V3, ESC_V4, ESC_V5})) begin
                add_char(v, STAT_DATA, 1'b1, fin);
            end else begin
                for (int k = 0; k < 10; k++) begin
                    case (k)
                        0, 9:    ch = "/";
                        1, 8:    ch = "%";
                        2:       ch = "D";
                        3:       ch = "C";
                        4:       ch = "N";
                        5:       ch = 8'(48 + v / 100);
                        6:       ch = 8'(48 + (v / 10) % 10);
                        default: ch = 8'(48 + v % 10);
                    endcase
                    add_char(ch, STAT_DATA, k == 9, (k == 9) && fin);
                end
            end
        end
    endfunction

    function void match_key_char(logic [7:0] ch, logic [2:0] user, logic last);
        t_key_char e;
        if (pending_chars.size() == 0) begin
            $error("unexpected key item: key_char %0d tuser %0d tlast %0d", ch, user, last);
            errors++;
            return;
        end
        e = pending_chars.pop_front();
        if (ch !== e.ch) begin
            $error("key_char expected %0d actual %0d", e.ch, ch);
            errors++;
        end
        if (user[1:0] !== e.st) begin
            $error("status expected %0d actual %0d", e.st, user[1:0]);
            errors++;
        end
        if (last !== e.last) begin
            $error("run_last expected %0d actual %0d", e.last, last);
            errors++;
        end
        if (user[2] !== e.fin) begin
            $error("key_finished expected %0d actual %0d", e.fin, user[2]);
            errors++;
        end
    endfunction
endclass

module lock_to_key_transform_top_tb;
    localparam int   LOCK_DEPTH = 256;
    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_DRAIN   = 1'b1;
    localparam int   ITEM_COUNT = 320;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_s_tvalid;
    logic       o_s_tready;
    logic [7:0] i_s_tdata;
    logic       i_s_tuser;
    logic       i_s_tlast;
    logic       o_m_tvalid;
    logic       i_m_tready;
    logic [7:0] o_m_tdata;
    logic [2:0] o_m_tuser;
    logic       o_m_tlast;

    key_char_ledger ledger;
    int unsigned    n_items;
    int unsigned    burst_left;
    logic [7:0]     last_lock_byte;
    bit             hold_done;
    bit             ovf_done;

    lock_to_key_transform_top #(
        .MAX_LOCK(LOCK_DEPTH)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic offer(input logic op, input logic [7:0] b, input logic lock_end);
        if (burst_left == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 10);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= b;
        i_s_tlast  <= lock_end;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        ledger.take_lock_item(op, b, lock_end);
        if (op == OP_LOAD) last_lock_byte = b;
        n_items++;
        burst_left--;
    endtask

    // load a byte that makes the next key byte equal to key
    task automatic load_for_key(input logic [7:0] key, input logic lock_end);
        offer(OP_LOAD, last_lock_byte ^ {key[3:0], key[7:4]}, lock_end);
    endtask

    task automatic drain_n(input int unsigned n);
        repeat (n) offer(OP_DRAIN, 8'($urandom), 1'($urandom));
    endtask

    task automatic run_lock(input int unsigned len, input int unsigned drains);
        logic [7:0] esc [6];
        esc = '{ESC_V0, ESC_V1, ESC_V2, ESC_V3, ESC_V4, ESC_V5};
        for (int unsigned i = 0; i < len; i++) begin
            if (i > 0 && $urandom_range(0, 3) == 0)
                load_for_key(esc[$urandom_range(0, 5)], i == len - 1);
            else
                offer(OP_LOAD, 8'($urandom), i == len - 1);
            if (i < len - 1 && $urandom_range(0, 19) == 0) drain_n(1);
        end
        drain_n(drains);
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = OP_LOAD;
        i_s_tlast  = 1'b0;
        i_m_tready = 1'b0;
        ledger     = new();
        n_items    = 0;
        burst_left = 4;
        last_lock_byte = '0;
        ovf_done   = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        drain_n(1);
        offer(OP_LOAD, 8'hFF, 1'b1);
        drain_n(1);
        offer(OP_LOAD, 8'h00, 1'b0);
        offer(OP_LOAD, 8'h00, 1'b1);
        drain_n(1);
        offer(OP_LOAD, 8'hFF, 1'b0);
        load_for_key(ESC_V0, 1'b0);
        load_for_key(ESC_V5, 1'b0);
        drain_n(1);
        load_for_key(ESC_V2, 1'b0);
        load_for_key(ESC_V3, 1'b0);
        load_for_key(ESC_V4, 1'b0);
        load_for_key(ESC_V1, 1'b1);
        drain_n(8);

        while (n_items < ITEM_COUNT) begin
            if (!ovf_done && n_items > 30) begin
                ovf_done = 1;
                run_lock(LOCK_DEPTH + $urandom_range(1, 3), 2);
            end else if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 4))
                    offer(1'($urandom), 8'($urandom), 1'($urandom));
            end else if ($urandom_range(0, 7) == 0) begin
                run_lock($urandom_range(1, 2), $urandom_range(1, 2));
            end else begin
                int unsigned len;
                len = $urandom_range(3, 24);
                if ($urandom_range(0, 4) == 0)
                    run_lock(len, $urandom_range(0, len));
                else
                    run_lock(len, len + $urandom_range(0, 2));
            end
        end

        i_s_tvalid <= 1'b0;
        while (ledger.pending_chars.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (ledger.errors == 0 && ledger.pending_chars.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        int unsigned hold_left;
        int unsigned mode;
        int unsigned mode_left;
        hold_done = 0;
        hold_left = 0;
        mode      = 0;
        mode_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid && i_m_tready)
                ledger.match_key_char(o_m_tdata, o_m_tuser, o_m_tlast);
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 2);
                mode_left = $urandom_range(10, 80);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else if (!hold_done && n_items >= 14) begin
                hold_done = 1;
                hold_left = 400;
                i_m_tready <= 1'b0;
            end else begin
                case (mode)
                    0:       i_m_tready <= 1'b1;
                    1:       i_m_tready <= ($urandom_range(0, 3) != 0);
                    default: i_m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial begin
        #3_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

>>> sim.f
hdl/ltk_pkg.sv
hdl/ltk_key_ram.sv
hdl/lock_to_key_transform_top.sv
hdl/ltk_checker.sv
test/lock_to_key_transform_top_tb.sv
